// ----- rtl/tilt_direction_and_repeat_core_defines.svh -----
// Assertion macros shared by the tilt direction and repeat RTL.
`ifndef TILT_DIRECTION_AND_REPEAT_CORE_DEFINES_SVH
`define TILT_DIRECTION_AND_REPEAT_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is low.
`define TDR_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define TDR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/tdr_pkg.sv -----
// Types, widths and codes shared by the tilt direction and repeat block.
package tdr_pkg;

    localparam int SAMPLE_BITS = 13;

    localparam int THR_W      = 12;
    localparam int MAX_W      = 7;
    localparam int RATE_W     = 8;
    localparam int DIV_W      = 5;
    localparam int CNT_W      = 10;
    localparam int DIR_W      = 3;
    localparam int MOVE_W     = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 12;

    // compare width covers samples, thresholds and their negation
    localparam int CMP_W  = ((SAMPLE_BITS > THR_W) ? SAMPLE_BITS : THR_W) + 2;
    // signed (max -+ speed) and its double
    localparam int DIFF_W = RATE_W + 2;
    // magnitude of the doubled difference, also the quotient width
    localparam int NUM_W  = RATE_W + 1;
    localparam int DIV_STEPS = NUM_W;
    localparam int STEP_W = $clog2(DIV_STEPS + 1);
    localparam int REM_W  = DIV_W + 1;
    localparam int LIM_W  = ((CNT_W + 1) > (NUM_W + 2)) ? (CNT_W + 1) : (NUM_W + 2);
    // largest count that survives a step without firing
    localparam int CNT_BOUND = 2 * ((1 << MAX_W) - 1) + 1;

    localparam logic [DIR_W-1:0] DIR_NONE  = 3'd0;
    localparam logic [DIR_W-1:0] DIR_UP    = 3'd1;
    localparam logic [DIR_W-1:0] DIR_DOWN  = 3'd2;
    localparam logic [DIR_W-1:0] DIR_LEFT  = 3'd3;
    localparam logic [DIR_W-1:0] DIR_RIGHT = 3'd4;

    localparam logic [MOVE_W-1:0] MOVE_STAY = 2'd0;
    localparam logic [MOVE_W-1:0] MOVE_POS  = 2'd1;
    localparam logic [MOVE_W-1:0] MOVE_NEG  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_RATE_CEIL  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RATE_FLOOR = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DIVISOR    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SIDE_THR   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_UP_THR     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_DOWN_THR   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_DEAD_ZONE  = 3'd6;

    localparam logic [MAX_W-1:0]         RATE_CEIL_RST  = 7'd100;
    localparam logic signed [RATE_W-1:0] RATE_FLOOR_RST = -8'sd100;
    localparam logic [DIV_W-1:0]         DIVISOR_RST    = 5'd1;
    localparam logic [THR_W-1:0]         SIDE_THR_RST   = 12'd90;
    localparam logic [THR_W-1:0]         UP_THR_RST     = 12'd35;
    localparam logic [THR_W-1:0]         DOWN_THR_RST   = 12'd100;
    localparam logic [THR_W-1:0]         DEAD_ZONE_RST  = 12'd45;

    typedef logic signed [SAMPLE_BITS-1:0] t_sample;

    typedef struct packed {
        logic [MAX_W-1:0]         rate_ceil;
        logic signed [RATE_W-1:0] rate_floor;
        logic [DIV_W-1:0]         divisor;
        logic [THR_W-1:0]         side_thr;
        logic [THR_W-1:0]         up_thr;
        logic [THR_W-1:0]         down_thr;
        logic [THR_W-1:0]         dead_zone;
    } t_cfg;

    typedef struct packed {
        logic [MOVE_W-1:0]        move;
        logic signed [RATE_W-1:0] rate;
    } t_lane_res;

    typedef struct packed {
        logic [DIR_W-1:0]         dir;
        logic [MOVE_W-1:0]        x_move;
        logic [MOVE_W-1:0]        y_move;
        logic signed [RATE_W-1:0] x_rate;
        logic signed [RATE_W-1:0] y_rate;
    } t_result;

endpackage

// ----- rtl/tdr_if.sv -----
// Channel interfaces: sample input, result output and register write port.
interface tdr_in_if;
    logic                                   valid;
    logic                                   ready;
    logic signed [tdr_pkg::SAMPLE_BITS-1:0] accel_x;
    logic signed [tdr_pkg::SAMPLE_BITS-1:0] accel_y;
    logic signed [tdr_pkg::SAMPLE_BITS-1:0] accel_z;

    modport source (output valid, accel_x, accel_y, accel_z, input ready);
    modport sink   (input valid, accel_x, accel_y, accel_z, output ready);
endinterface

interface tdr_res_if;
    logic                              valid;
    logic                              ready;
    logic [tdr_pkg::DIR_W-1:0]         tilt_direction;
    logic [tdr_pkg::MOVE_W-1:0]        x_move;
    logic [tdr_pkg::MOVE_W-1:0]        y_move;
    logic signed [tdr_pkg::RATE_W-1:0] x_rate;
    logic signed [tdr_pkg::RATE_W-1:0] y_rate;

    modport source (output valid, tilt_direction, x_move, y_move, x_rate, y_rate,
                    input ready);
    modport sink   (input valid, tilt_direction, x_move, y_move, x_rate, y_rate,
                    output ready);
endinterface

interface tdr_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [tdr_pkg::CFG_IDX_W-1:0]     index;
    logic [tdr_pkg::CFG_DATA_W-1:0]    data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ----- rtl/tdr_axis_lane.sv -----
// One axis lane: speed limiting, serial interval divide and repeat counter.
`include "tilt_direction_and_repeat_core_defines.svh"

module tdr_axis_lane (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  tdr_pkg::t_sample   i_sample,
    input  tdr_pkg::t_cfg      i_cfg,
    input  logic               i_take,
    output logic               o_done,
    output tdr_pkg::t_lane_res o_res
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_LOAD = 2'd1;
    localparam logic [1:0] ST_DIV  = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    logic [1:0]                        r_state;
    logic [tdr_pkg::STEP_W-1:0]        r_step;
    logic signed [tdr_pkg::RATE_W-1:0] r_speed;
    logic [tdr_pkg::NUM_W-1:0]         r_num;
    logic                              r_neg;
    logic [tdr_pkg::DIV_W-1:0]         r_div;
    logic [tdr_pkg::REM_W-2:0]         r_rem;
    logic [tdr_pkg::CNT_W-1:0]         r_cnt;
    logic                              r_last_pos;

    // speed from the sample
    logic signed [tdr_pkg::CMP_W-1:0]  v_ext;
    logic signed [tdr_pkg::CMP_W-1:0]  v_mag;
    logic signed [tdr_pkg::CMP_W-1:0]  v_half;
    logic signed [tdr_pkg::CMP_W-1:0]  dz_ext;
    logic signed [tdr_pkg::CMP_W-1:0]  max_ext;
    logic signed [tdr_pkg::CMP_W-1:0]  min_ext;
    logic signed [tdr_pkg::RATE_W-1:0] speed;

    always_comb begin
        v_ext   = tdr_pkg::CMP_W'(i_sample);
        v_mag   = v_ext[tdr_pkg::CMP_W-1] ? -v_ext : v_ext;
        v_half  = (v_ext + $signed({{(tdr_pkg::CMP_W-1){1'b0}}, v_ext[tdr_pkg::CMP_W-1]}))
                  >>> 1;
        dz_ext  = $signed({{(tdr_pkg::CMP_W-tdr_pkg::THR_W){1'b0}}, i_cfg.dead_zone});
        max_ext = $signed({{(tdr_pkg::CMP_W-tdr_pkg::MAX_W){1'b0}}, i_cfg.rate_ceil});
        min_ext = tdr_pkg::CMP_W'($signed(i_cfg.rate_floor));
        priority if (v_mag < dz_ext) begin
            speed = '0;
        end else if (v_half > max_ext) begin
            speed = $signed({1'b0, i_cfg.rate_ceil});
        end else if (v_half < min_ext) begin
            speed = $signed(i_cfg.rate_floor);
        end else begin
            speed = v_half[tdr_pkg::RATE_W-1:0];
        end
    end

    // doubled distance of the speed from the limit, as sign and magnitude
    logic                              pos;
    logic signed [tdr_pkg::DIFF_W-1:0] s_ext;
    logic signed [tdr_pkg::DIFF_W-1:0] m_ext;
    logic signed [tdr_pkg::DIFF_W-1:0] diff2;
    logic signed [tdr_pkg::DIFF_W-1:0] diff2_mag;

    assign pos       = (r_speed > 0);
    assign s_ext     = tdr_pkg::DIFF_W'(r_speed);
    assign m_ext     = $signed({{(tdr_pkg::DIFF_W-tdr_pkg::MAX_W){1'b0}}, i_cfg.rate_ceil});
    assign diff2     = (pos ? (m_ext - s_ext) : (m_ext + s_ext)) <<< 1;
    assign diff2_mag = diff2[tdr_pkg::DIFF_W-1] ? -diff2 : diff2;

    // restoring divide, one quotient bit a cycle
    logic [tdr_pkg::REM_W-1:0] trial;
    logic                      q_bit;
    logic [tdr_pkg::REM_W-1:0] rem_sub;

    assign trial   = {r_rem, r_num[tdr_pkg::NUM_W-1]};
    assign q_bit   = (trial >= {1'b0, r_div});
    assign rem_sub = q_bit ? (trial - {1'b0, r_div}) : trial;

    // repeat decision
    logic signed [tdr_pkg::LIM_W-1:0] q_ext;
    logic signed [tdr_pkg::LIM_W-1:0] lim;
    logic [tdr_pkg::CNT_W-1:0]        cnt_base;
    logic [tdr_pkg::CNT_W-1:0]        cnt_inc;
    logic                             fire;
    logic [tdr_pkg::MOVE_W-1:0]       move;
    logic [tdr_pkg::CNT_W-1:0]        n_cnt;

    always_comb begin
        q_ext    = $signed({{(tdr_pkg::LIM_W-tdr_pkg::NUM_W){1'b0}}, r_num});
        lim      = (r_neg ? -q_ext : q_ext) + tdr_pkg::LIM_W'(1);
        cnt_base = (pos != r_last_pos) ? '0 : r_cnt;
        cnt_inc  = cnt_base + tdr_pkg::CNT_W'(1);
        fire     = ($signed({{(tdr_pkg::LIM_W-tdr_pkg::CNT_W){1'b0}}, cnt_inc}) > lim);
        if (r_speed == 0) begin
            move  = tdr_pkg::MOVE_STAY;
            n_cnt = '0;
        end else if (fire) begin
            move  = pos ? tdr_pkg::MOVE_POS : tdr_pkg::MOVE_NEG;
            n_cnt = '0;
        end else begin
            move  = tdr_pkg::MOVE_STAY;
            n_cnt = cnt_inc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_step     <= '0;
            r_cnt      <= '0;
            r_last_pos <= 1'b0;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (i_start) begin
                        r_speed <= speed;
                        r_state <= ST_LOAD;
                    end
                end
                ST_LOAD: begin
                    r_num   <= diff2_mag[tdr_pkg::NUM_W-1:0];
                    r_neg   <= diff2[tdr_pkg::DIFF_W-1];
                    r_div   <= (i_cfg.divisor == '0) ? tdr_pkg::DIV_W'(1) : i_cfg.divisor;
                    r_rem   <= '0;
                    r_step  <= '0;
                    r_state <= ST_DIV;
                end
                ST_DIV: begin
                    r_num  <= {r_num[tdr_pkg::NUM_W-2:0], q_bit};
                    r_rem  <= rem_sub[tdr_pkg::REM_W-2:0];
                    r_step <= r_step + tdr_pkg::STEP_W'(1);
                    if (r_step == tdr_pkg::STEP_W'(tdr_pkg::DIV_STEPS - 1)) begin
                        r_state <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    // commit the counter only when the merged result is taken
                    if (i_take) begin
                        r_cnt <= n_cnt;
                        if (r_speed != 0) begin
                            r_last_pos <= pos;
                        end
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_done     = (r_state == ST_DONE);
    assign o_res.move = move;
    assign o_res.rate = r_speed;

    `TDR_ASSERT_IMPL(a_step_range, i_clk, i_rst_n, r_state == ST_DIV,
        r_step < tdr_pkg::STEP_W'(tdr_pkg::DIV_STEPS), "divide step past last bit")
    `TDR_ASSERT_IMPL(a_cnt_bound, i_clk, i_rst_n, 1'b1,
        r_cnt <= tdr_pkg::CNT_W'(tdr_pkg::CNT_BOUND), "repeat count above largest limit")
    `TDR_ASSERT_IMPL(a_take_when_done, i_clk, i_rst_n, i_take,
        r_state == ST_DONE, "lane result taken before it was ready")

endmodule

// ----- rtl/tdr_merge.sv -----
// Merge stage: tilt direction from the corrected sample, joined with both lanes.
module tdr_merge (
    input  tdr_pkg::t_sample   i_x,
    input  tdr_pkg::t_sample   i_y,
    input  logic               i_swap,
    input  tdr_pkg::t_cfg      i_cfg,
    input  tdr_pkg::t_lane_res i_x_res,
    input  tdr_pkg::t_lane_res i_y_res,
    output tdr_pkg::t_result   o_res
);

    logic signed [tdr_pkg::CMP_W-1:0] x_ext;
    logic signed [tdr_pkg::CMP_W-1:0] y_ext;
    logic signed [tdr_pkg::CMP_W-1:0] side_ext;
    logic signed [tdr_pkg::CMP_W-1:0] up_ext;
    logic signed [tdr_pkg::CMP_W-1:0] down_ext;
    logic [tdr_pkg::DIR_W-1:0]        dir;

    always_comb begin
        x_ext    = tdr_pkg::CMP_W'(i_x);
        y_ext    = tdr_pkg::CMP_W'(i_y);
        side_ext = $signed({{(tdr_pkg::CMP_W-tdr_pkg::THR_W){1'b0}}, i_cfg.side_thr});
        // upside down: up and down thresholds trade places
        up_ext   = $signed({{(tdr_pkg::CMP_W-tdr_pkg::THR_W){1'b0}},
                            i_swap ? i_cfg.down_thr : i_cfg.up_thr});
        down_ext = $signed({{(tdr_pkg::CMP_W-tdr_pkg::THR_W){1'b0}},
                            i_swap ? i_cfg.up_thr : i_cfg.down_thr});
        priority if (x_ext < -side_ext) begin
            dir = ((y_ext < -up_ext) && (y_ext < x_ext)) ? tdr_pkg::DIR_UP
                                                         : tdr_pkg::DIR_RIGHT;
        end else if (x_ext > side_ext) begin
            dir = ((y_ext > down_ext) && (y_ext > x_ext)) ? tdr_pkg::DIR_DOWN
                                                          : tdr_pkg::DIR_LEFT;
        end else if (y_ext < -up_ext) begin
            dir = tdr_pkg::DIR_UP;
        end else if (y_ext > down_ext) begin
            dir = tdr_pkg::DIR_DOWN;
        end else begin
            dir = tdr_pkg::DIR_NONE;
        end
    end

    assign o_res.dir    = dir;
    assign o_res.x_move = i_x_res.move;
    assign o_res.y_move = i_y_res.move;
    assign o_res.x_rate = i_x_res.rate;
    assign o_res.y_rate = i_y_res.rate;

endmodule

// ----- rtl/tilt_direction_and_repeat_core.sv -----
// Top level of the tilt direction and repeat block: config, lanes, merge, output.
//
//   channel  | dir | beat carries
//   ---------+-----+--------------------------------------------------------
//   i_in     | in  | accel_x, accel_y, accel_z (signed samples)
//   o_res    | out | tilt_direction, x_move, y_move, x_rate, y_rate
//   i_cfg    | in  | index (register number), data (write value)
//
// An input beat reaches the result register in order: the accepting
// edge corrects and holds the sample, then the lanes limit the speed, load the
// divider, run the serial interval divide (one quotient bit a cycle in each lane)
// and commit the repeat counters. The next beat is accepted the cycle after, so
// a new sample is taken only once the last one has been committed.
// A full, untaken result register holds both lanes and the counters until it drains.
// Reset is synchronous, active low, and restores the register defaults.
`include "tilt_direction_and_repeat_core_defines.svh"

module tilt_direction_and_repeat_core (
    input  logic             i_clk,
    input  logic             i_rst_n,
    tdr_in_if.sink           i_in,
    tdr_res_if.source        o_res,
    tdr_cfg_if.sink          i_cfg
);

    // saturating negate: the most negative sample maps to the largest positive
    function automatic tdr_pkg::t_sample neg_sat(input tdr_pkg::t_sample v);
        tdr_pkg::t_sample most_neg;
        most_neg = {1'b1, {(tdr_pkg::SAMPLE_BITS-1){1'b0}}};
        if (v == most_neg) begin
            neg_sat = {1'b0, {(tdr_pkg::SAMPLE_BITS-1){1'b1}}};
        end else begin
            neg_sat = -v;
        end
    endfunction

    tdr_pkg::t_cfg      r_cfg;
    tdr_pkg::t_sample   r_x;
    tdr_pkg::t_sample   r_y;
    logic               r_swap;
    logic               r_busy;
    logic               r_start;
    logic               r_out_valid;
    tdr_pkg::t_result   r_out;

    logic               accept;
    logic               take;
    logic               x_done;
    logic               y_done;
    tdr_pkg::t_lane_res x_res;
    tdr_pkg::t_lane_res y_res;
    tdr_pkg::t_result   merged;

    // register writes: always ready, unknown indexes drop
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.rate_ceil  <= tdr_pkg::RATE_CEIL_RST;
            r_cfg.rate_floor <= tdr_pkg::RATE_FLOOR_RST;
            r_cfg.divisor    <= tdr_pkg::DIVISOR_RST;
            r_cfg.side_thr   <= tdr_pkg::SIDE_THR_RST;
            r_cfg.up_thr     <= tdr_pkg::UP_THR_RST;
            r_cfg.down_thr   <= tdr_pkg::DOWN_THR_RST;
            r_cfg.dead_zone  <= tdr_pkg::DEAD_ZONE_RST;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                tdr_pkg::REG_RATE_CEIL:  r_cfg.rate_ceil  <= i_cfg.data[tdr_pkg::MAX_W-1:0];
                tdr_pkg::REG_RATE_FLOOR: r_cfg.rate_floor <= i_cfg.data[tdr_pkg::RATE_W-1:0];
                tdr_pkg::REG_DIVISOR:    r_cfg.divisor    <= i_cfg.data[tdr_pkg::DIV_W-1:0];
                tdr_pkg::REG_SIDE_THR:   r_cfg.side_thr   <= i_cfg.data[tdr_pkg::THR_W-1:0];
                tdr_pkg::REG_UP_THR:     r_cfg.up_thr     <= i_cfg.data[tdr_pkg::THR_W-1:0];
                tdr_pkg::REG_DOWN_THR:   r_cfg.down_thr   <= i_cfg.data[tdr_pkg::THR_W-1:0];
                tdr_pkg::REG_DEAD_ZONE:  r_cfg.dead_zone  <= i_cfg.data[tdr_pkg::THR_W-1:0];
                default: ;
            endcase
        end
    end

    // one sample in flight; the result register decouples the output side
    assign i_in.ready = !r_busy;
    assign accept     = i_in.valid && !r_busy;
    // both lanes finish together; move the merged beat once the slot is free
    assign take       = x_done && y_done && (!r_out_valid || o_res.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_start     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_start <= accept;
            if (accept) begin
                r_busy <= 1'b1;
            end else if (take) begin
                r_busy <= 1'b0;
            end
            if (take) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // upside down: flip both axes before anything else looks at them
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_swap <= i_in.accel_z[tdr_pkg::SAMPLE_BITS-1];
            if (i_in.accel_z[tdr_pkg::SAMPLE_BITS-1]) begin
                r_x <= neg_sat(i_in.accel_x);
                r_y <= neg_sat(i_in.accel_y);
            end else begin
                r_x <= i_in.accel_x;
                r_y <= i_in.accel_y;
            end
        end
        if (take) begin
            r_out <= merged;
        end
    end

    tdr_axis_lane u_lane_x (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (r_start),
        .i_sample (r_x),
        .i_cfg    (r_cfg),
        .i_take   (take),
        .o_done   (x_done),
        .o_res    (x_res)
    );

    tdr_axis_lane u_lane_y (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (r_start),
        .i_sample (r_y),
        .i_cfg    (r_cfg),
        .i_take   (take),
        .o_done   (y_done),
        .o_res    (y_res)
    );

    tdr_merge u_merge (
        .i_x     (r_x),
        .i_y     (r_y),
        .i_swap  (r_swap),
        .i_cfg   (r_cfg),
        .i_x_res (x_res),
        .i_y_res (y_res),
        .o_res   (merged)
    );

    assign o_res.valid          = r_out_valid;
    assign o_res.tilt_direction = r_out.dir;
    assign o_res.x_move         = r_out.x_move;
    assign o_res.y_move         = r_out.y_move;
    assign o_res.x_rate         = r_out.x_rate;
    assign o_res.y_rate         = r_out.y_rate;

    `TDR_ASSERT_IMPL(a_lanes_agree, i_clk, i_rst_n, 1'b1,
        x_done == y_done, "axis lanes out of step")
    `TDR_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, accept,
        r_busy && r_start, "accepted beat did not start the lanes")
    `TDR_ASSERT_IMPL(a_take_busy, i_clk, i_rst_n, take,
        r_busy && !r_start, "result taken with no sample in flight")

endmodule

// ----- test/tilt_direction_and_repeat_core_tb.sv -----
// Self-checking testbench for the tilt direction and repeat core.
module tilt_direction_and_repeat_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tdr_pkg::*;

    localparam int SAMPLE_MAX = (1 << (SAMPLE_BITS - 1)) - 1;
    localparam int SAMPLE_MIN = -(1 << (SAMPLE_BITS - 1));
    localparam int CNT_MASK   = (1 << CNT_W) - 1;

    typedef struct packed {
        t_sample x;
        t_sample y;
        t_sample z;
    } t_poll;

    // Clock, reset and every block input start at known values.
    logic                  i_clk     = 1'b0;
    logic                  i_rst_n   = 1'b0;
    logic                  poll_valid = 1'b0;
    t_sample               poll_x    = '0;
    t_sample               poll_y    = '0;
    t_sample               poll_z    = '0;
    logic                  res_ready = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = REG_RATE_CEIL;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    tdr_in_if  in_ch ();
    tdr_res_if res_ch ();
    tdr_cfg_if cfg_ch ();

    assign in_ch.valid    = poll_valid;
    assign in_ch.accel_x  = poll_x;
    assign in_ch.accel_y  = poll_y;
    assign in_ch.accel_z  = poll_z;
    assign res_ch.ready   = res_ready;
    assign cfg_ch.valid   = cfg_valid;
    assign cfg_ch.index   = cfg_index;
    assign cfg_ch.data    = cfg_data;

    tilt_direction_and_repeat_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_res   (res_ch),
        .i_cfg   (cfg_ch)
    );

    // Shadow copy of the register file, starting from the reset defaults.
    int spd_max  = RATE_CEIL_RST;
    int spd_min  = RATE_FLOOR_RST;
    int rep_div  = DIVISOR_RST;
    int side_thr = SIDE_THR_RST;
    int up_thr   = UP_THR_RST;
    int down_thr = DOWN_THR_RST;
    int dz_thr   = DEAD_ZONE_RST;

    // Per-axis repeat counters and last sign, index 0 for x and 1 for y.
    int rep_cnt [2] = '{0, 0};
    bit rep_pos [2] = '{1'b0, 1'b0};

    t_poll      poll_q [$];       // samples waiting to be driven
    t_result    predicted_q [$];  // results owed by the block, oldest first

    int n_err      = 0;
    int n_queued   = 0;
    int n_polls    = 0;
    int n_results  = 0;
    int n_xmoves   = 0;
    int n_ymoves   = 0;
    int n_settings = 1;

    int poll_wait  = 0;
    int poll_burst = 0;
    int res_stall  = 0;
    int res_burst  = 0;

    // Draw the idle cycles before the next beat; now and then open a run
    // of back-to-back beats so that full-rate stretches get exercised too.
    function automatic int draw_wait(inout int burst);
        if (burst > 0) begin
            burst--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0) begin
            burst = $urandom_range(8, 40);
            return 0;
        end
        return $urandom_range(0, 11);
    endfunction

    // Negate a sample, saturating the most negative one to the top value.
    function automatic int flip_sat(int v);
        return (-v > SAMPLE_MAX) ? SAMPLE_MAX : -v;
    endfunction

    // Dead zone, halve toward zero, then clamp: upper limit checked first.
    function automatic int shape_rate(int v);
        int mag;
        int s;
        mag = (v < 0) ? -v : v;
        if (mag < dz_thr)
            return 0;
        s = v / 2;
        if (s > spd_max)
            s = spd_max;
        else if (s < spd_min)
            s = spd_min;
        return s;
    endfunction

    // Advance one axis repeat counter and return the move it fires, if any.
    function automatic logic [MOVE_W-1:0] step_repeat(int axis, int s);
        int  div;
        int  lim;
        bit  p;
        if (s == 0) begin
            rep_cnt[axis] = 0;
            return MOVE_STAY;
        end
        div = (rep_div == 0) ? 1 : rep_div;
        p = (s > 0);
        if (p != rep_pos[axis]) begin
            rep_cnt[axis] = 0;
            rep_pos[axis] = p;
        end
        // a negative speed uses max + s, so an out-of-range clamp can push
        // the limit below zero and fire at once
        lim = (p ? spd_max - s : spd_max + s) * 2 / div + 1;
        rep_cnt[axis] = (rep_cnt[axis] + 1) & CNT_MASK;
        if (rep_cnt[axis] > lim) begin
            rep_cnt[axis] = 0;
            return p ? MOVE_POS : MOVE_NEG;
        end
        return MOVE_STAY;
    endfunction

    // Work out the result of one accepted poll and advance the counters.
    function automatic t_result predict_poll(t_poll p);
        int      x;
        int      y;
        int      tu;
        int      td;
        int      xs;
        int      ys;
        t_result r;
        x  = p.x;
        y  = p.y;
        tu = up_thr;
        td = down_thr;
        // upside down: mirror both axes and swap the up/down thresholds
        if (p.z < 0) begin
            x  = flip_sat(x);
            y  = flip_sat(y);
            tu = down_thr;
            td = up_thr;
        end
        if (x < -side_thr)
            r.dir = (y < -tu && y < x) ? DIR_UP : DIR_RIGHT;
        else if (x > side_thr)
            r.dir = (y > td && y > x) ? DIR_DOWN : DIR_LEFT;
        else if (y < -tu)
            r.dir = DIR_UP;
        else if (y > td)
            r.dir = DIR_DOWN;
        else
            r.dir = DIR_NONE;
        xs = shape_rate(x);
        ys = shape_rate(y);
        r.x_move = step_repeat(0, xs);
        r.y_move = step_repeat(1, ys);
        r.x_rate = xs[RATE_W-1:0];
        r.y_rate = ys[RATE_W-1:0];
        return r;
    endfunction

    task automatic check_field(string fld, int want, int got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, fld, want, got);
            n_err++;
        end
    endtask

    // Clock: 10 ns period.
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Poll driver: hold the beat while the block stalls, otherwise count
    // down the drawn gap and then present the next queued sample.
    always @(posedge i_clk) begin
        t_poll      cur;
        t_poll      nxt;
        logic       hold;
        if (!i_rst_n) begin
            poll_valid <= 1'b0;
        end else begin
            hold = poll_valid && !in_ch.ready;
            if (poll_valid && in_ch.ready) begin
                // beat taken: predict now, with the counters as they stand
                cur.x = poll_x;
                cur.y = poll_y;
                cur.z = poll_z;
                predicted_q.push_back(predict_poll(cur));
                n_polls++;
            end
            if (!hold) begin
                if (poll_wait > 0) begin
                    poll_wait--;
                    poll_valid <= 1'b0;
                end else if (poll_q.size() > 0) begin
                    nxt = poll_q.pop_front();
                    poll_x     <= nxt.x;
                    poll_y     <= nxt.y;
                    poll_z     <= nxt.z;
                    poll_valid <= 1'b1;
                    poll_wait  = draw_wait(poll_burst);
                end else begin
                    poll_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor: compare each taken beat against the oldest prediction,
    // then drop ready for a drawn number of cycles.
    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            res_ready <= 1'b0;
        end else begin
            if (res_ready && res_ch.valid) begin
                n_results++;
                if (predicted_q.size() == 0) begin
                    $display("%0t: result with no poll pending, got dir %0d moves %0d/%0d",
                             $time, res_ch.tilt_direction, res_ch.x_move, res_ch.y_move);
                    n_err++;
                end else begin
                    want = predicted_q.pop_front();
                    check_field("tilt_direction", want.dir, res_ch.tilt_direction);
                    check_field("x_move", want.x_move, res_ch.x_move);
                    check_field("y_move", want.y_move, res_ch.y_move);
                    check_field("x_rate", want.x_rate, res_ch.x_rate);
                    check_field("y_rate", want.y_rate, res_ch.y_rate);
                end
                if (res_ch.x_move != MOVE_STAY)
                    n_xmoves++;
                if (res_ch.y_move != MOVE_STAY)
                    n_ymoves++;
                res_stall = draw_wait(res_burst);
            end
            if (res_stall > 0) begin
                res_stall--;
                res_ready <= 1'b0;
            end else begin
                res_ready <= 1'b1;
            end
        end
    end

    // Hard stop far beyond the slowest legal run.
    initial begin
        #5_000_000;
        $display("simulation failed");
        $finish;
    end

    task automatic add_poll(int x, int y, int z);
        t_poll p;
        p.x = t_sample'(x);
        p.y = t_sample'(y);
        p.z = t_sample'(z);
        poll_q.push_back(p);
        n_queued++;
    endtask

    // Register write: hold the beat until the port takes it, then mirror it.
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        @(posedge i_clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge i_clk); while (!cfg_ch.ready);
        cfg_valid <= 1'b0;
        case (idx)
            REG_RATE_CEIL:  spd_max  = val[MAX_W-1:0];
            REG_RATE_FLOOR: spd_min  = $signed(val[RATE_W-1:0]);
            REG_DIVISOR:    rep_div  = val[DIV_W-1:0];
            REG_SIDE_THR:   side_thr = val[THR_W-1:0];
            REG_UP_THR:     up_thr   = val[THR_W-1:0];
            REG_DOWN_THR:   down_thr = val[THR_W-1:0];
            REG_DEAD_ZONE:  dz_thr   = val[THR_W-1:0];
            default: ;
        endcase
    endtask

    task automatic apply_setting(int mx, int mn, int dv, int sd, int up, int dn, int dz);
        write_reg(REG_RATE_CEIL,  CFG_DATA_W'(mx));
        write_reg(REG_RATE_FLOOR, CFG_DATA_W'(mn));
        write_reg(REG_DIVISOR,    CFG_DATA_W'(dv));
        write_reg(REG_SIDE_THR,   CFG_DATA_W'(sd));
        write_reg(REG_UP_THR,     CFG_DATA_W'(up));
        write_reg(REG_DOWN_THR,   CFG_DATA_W'(dn));
        write_reg(REG_DEAD_ZONE,  CFG_DATA_W'(dz));
        n_settings++;
    endtask

    // Block until every queued poll has come back, then let the pipe settle
    // a bit longer than one pass through the block.
    task automatic wait_drained();
        do @(posedge i_clk); while (n_results < n_queued);
        repeat (20) @(posedge i_clk);
    endtask

    function automatic int full_sample();
        return int'($urandom_range(0, SAMPLE_MAX - SAMPLE_MIN)) + SAMPLE_MIN;
    endfunction

    // Level for a run: mostly around the thresholds, some full scale,
    // some exact extremes.
    function automatic int pick_level();
        case ($urandom_range(0, 19))
            0:             return SAMPLE_MIN;
            1:             return SAMPLE_MAX;
            2:             return 0;
            3:             return -1;
            4, 5, 6, 7, 8: return full_sample();
            default:       return int'($urandom_range(0, 600)) - 300;
        endcase
    endfunction

    function automatic int jitter(int v);
        int j;
        j = v + int'($urandom_range(0, 6)) - 3;
        if (j > SAMPLE_MAX)
            j = SAMPLE_MAX;
        if (j < SAMPLE_MIN)
            j = SAMPLE_MIN;
        return j;
    endfunction

    // Random polls: mostly steady tilts held long enough for the repeat
    // counters to fire, mixed with single noise samples that break runs.
    task automatic queue_random(int count);
        int done;
        int bx;
        int by;
        int bz;
        int len;
        done = 0;
        while (done < count) begin
            if ($urandom_range(0, 4) == 0) begin
                add_poll(full_sample(), full_sample(), full_sample());
                done++;
            end else begin
                bx  = pick_level();
                by  = pick_level();
                bz  = pick_level();
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 200)
                                                  : $urandom_range(2, 30);
                // cut the last run so the batch lands on its count
                if (len > count - done)
                    len = count - done;
                repeat (len) begin
                    add_poll(jitter(bx), jitter(by), bz);
                    done++;
                end
            end
        end
    endtask

    initial begin
        // Hold reset low at the start, then release it, once.
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed polls on the reset defaults: every direction, the
        // corner branches, upside-down handling and saturation.
        add_poll(0, 0, 100);            // flat: none
        add_poll(0, -200, 100);         // up
        add_poll(0, 200, 100);          // down
        add_poll(200, 0, 100);          // left
        add_poll(-200, 0, 100);         // right
        add_poll(-100, -300, 100);      // far left side, y steeper: up
        add_poll(-300, -100, 100);      // far left side, x steeper: right
        add_poll(100, 300, 100);        // far right side, y steeper: down
        add_poll(300, 100, 100);        // far right side, x steeper: left
        add_poll(0, -50, -1);           // upside down, thresholds swapped: down
        add_poll(0, 50, 100);           // same magnitude upright: none
        add_poll(SAMPLE_MIN, SAMPLE_MIN, SAMPLE_MIN);  // negation saturates
        add_poll(SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX);
        add_poll(SAMPLE_MIN, SAMPLE_MAX, 0);
        add_poll(44, -44, 1);           // just inside the dead zone
        add_poll(45, -45, 1);           // on the dead zone edge
        repeat (4) add_poll(SAMPLE_MAX, 0, 1);   // clamp high, fire positive moves
        repeat (3) add_poll(SAMPLE_MIN, 0, 1);   // sign flip, fire negative moves
        add_poll(0, SAMPLE_MIN, -1);
        add_poll(0, SAMPLE_MIN, -1);
        queue_random(150);
        wait_drained();

        // Widest symmetric clamp, a large divisor, zero thresholds.
        apply_setting(127, -127, 16, 0, 0, 0, 0);
        queue_random(150);
        wait_drained();

        // Narrowest clamp, full-scale thresholds and dead zone.
        apply_setting(1, -1, 1, 4095, 4095, 4095, 4095);
        queue_random(120);
        wait_drained();

        // Lower clamp below -max: the repeat limit goes negative.
        apply_setting(1, -127, 1, $urandom_range(0, 300), $urandom_range(0, 300),
                      $urandom_range(0, 300), 10);
        queue_random(150);
        wait_drained();

        // Out-of-range settings: zero max, positive min, zero divisor.
        apply_setting(0, 5, 0, 50, 30, 60, 20);
        queue_random(150);
        wait_drained();

        // Most negative min and a divisor above the usual range.
        apply_setting(127, -128, 31, 100, 100, 100, 0);
        queue_random(150);
        wait_drained();

        repeat (3) begin
            apply_setting($urandom_range(1, 127), -int'($urandom_range(1, 127)),
                          $urandom_range(1, 16), $urandom_range(0, 400),
                          $urandom_range(0, 300), $urandom_range(0, 300),
                          $urandom_range(0, 200));
            queue_random(150);
            wait_drained();
        end

        repeat (10) @(posedge i_clk);
        $display("%0d polls checked across %0d register settings", n_results, n_settings);
        $display("%0d x moves and %0d y moves fired, %0d mismatches",
                 n_xmoves, n_ymoves, n_err);
        if (n_err == 0 && predicted_q.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
